// ===== hw/rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// shared types and constants for the mouse packet tracker
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

    localparam int BYTE_W  = 8;
    localparam int MOVE_W  = 9;
    localparam int POS_W   = 10;
    localparam int BTN_W   = 3;
    localparam int CIDX_W  = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // bit positions within the head byte
    localparam int SYNC_POS  = 3;
    localparam int XSIGN_POS = 4;
    localparam int YSIGN_POS = 5;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_X_LIMIT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_Y_LIMIT = 2'd1;

    localparam logic [POS_W-1:0] X_LIMIT_RST = 10'd639;
    localparam logic [POS_W-1:0] Y_LIMIT_RST = 10'd199;

    // one-hot byte phase
    typedef enum logic [2:0] {
        PH_HEAD   = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    // decoded packet, valid only when done is set
    typedef struct packed {
        logic                     done;
        logic [BTN_W-1:0]         buttons;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } pmt_pkt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// frames ps/2 mouse bytes into packets and tracks a clamped pointer position
// ----------------------------------------------------------------------------
// usage:
//   bytes from the mouse enter on the s_ channel, one byte per word. every
//   third byte of a framed packet produces one word on the m_ channel with
//   the buttons, the signed movements and the clamped pointer position.
//   a first byte with bit 3 clear is dropped so framing can resync. cfg_ready
//   is always high. limits go in on cfg_ (index 0 x, 1 y); the user must write
//   them only while the block is idle, which the block does not enforce.
// throughput:
//   one byte is accepted per cycle while m_ is not stalled. a byte is decoded
//   and clamped while it sits in the input register, and the result word is
//   registered for m_ when the last byte of the packet leaves that register.
// reset:
//   limits return to 639 and 199, cursor to 0,0, framing waits for a head.
// stall:
//   when m_tready is low with a result pending, the input register holds
//   and s_tready drops once it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // slave byte stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pmt_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    // master result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] button_bits, [11:3] move_x, [20:12] move_y, [30:21] pos_x,
    // [40:31] pos_y, [47:41] zero
    output logic [pmt_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pmt_pkg::CIDX_W-1:0]          cfg_index,
    input  wire logic [pmt_pkg::POS_W-1:0]           cfg_data
);
    import pmt_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - (BTN_W + 2 * MOVE_W + 2 * POS_W);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // limit registers
    logic [POS_W-1:0]  x_limit_reg, y_limit_reg;

    // result register
    logic                      out_valid_reg;
    logic [BTN_W-1:0]          out_btn_reg;
    logic signed [MOVE_W-1:0]  out_mx_reg, out_my_reg;
    logic [POS_W-1:0]          out_px_reg, out_py_reg;

    logic              advance;
    pmt_pkt_t          pkt;
    logic [POS_W-1:0]  pos_x_next, pos_y_next;

    // the held byte moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata[BYTE_W-1:0];
    end

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_X_LIMIT: x_limit_reg <= cfg_data;
                CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    pmt_framer u_framer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .pkt     (pkt)
    );

    pmt_cursor u_cursor
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance && pkt.done),
        .move_x     (pkt.move_x),
        .move_y     (pkt.move_y),
        .x_limit    (x_limit_reg),
        .y_limit    (y_limit_reg),
        .pos_x_next (pos_x_next),
        .pos_y_next (pos_y_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= pkt.done;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && pkt.done)
        begin
            out_btn_reg <= pkt.buttons;
            out_mx_reg  <= pkt.move_x;
            out_my_reg  <= pkt.move_y;
            out_px_reg  <= pos_x_next;
            out_py_reg  <= pos_y_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_py_reg, out_px_reg,
                       out_my_reg, out_mx_reg, out_btn_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/pmt_framer.sv =====
// ----------------------------------------------------------------------------
// pmt_framer
// frames mouse bytes into three-byte packets and decodes movement
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_framer
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [pmt_pkg::BYTE_W-1:0]  rx_byte,
    output pmt_pkg::pmt_pkt_t                pkt
);
    import pmt_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  head_reg, head_next;
    logic [BYTE_W-1:0]  second_reg, second_next;

    always_comb
    begin
        phase_next  = phase_reg;
        head_next   = head_reg;
        second_next = second_reg;
        pkt.done    = 1'b0;
        pkt.buttons = head_reg[BTN_W-1:0];
        pkt.move_x  = {head_reg[XSIGN_POS], second_reg};
        pkt.move_y  = {head_reg[YSIGN_POS], rx_byte};
        unique case (phase_reg)
            PH_SECOND:
            begin
                second_next = rx_byte;
                phase_next  = PH_THIRD;
            end
            PH_THIRD:
            begin
                pkt.done   = 1'b1;
                phase_next = PH_HEAD;
            end
            default:
            begin
                // resync: drop bytes without the always-one bit
                if (rx_byte[SYNC_POS])
                begin
                    head_next  = rx_byte;
                    phase_next = PH_SECOND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            head_reg   <= '0;
            second_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            head_reg   <= head_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pmt_cursor.sv =====
// ----------------------------------------------------------------------------
// pmt_cursor
// pointer position accumulator with clamping to configured limits
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_cursor
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic signed [pmt_pkg::MOVE_W-1:0]  move_x,
    input  wire logic signed [pmt_pkg::MOVE_W-1:0]  move_y,
    input  wire logic [pmt_pkg::POS_W-1:0]          x_limit,
    input  wire logic [pmt_pkg::POS_W-1:0]          y_limit,
    output logic [pmt_pkg::POS_W-1:0]               pos_x_next,
    output logic [pmt_pkg::POS_W-1:0]               pos_y_next
);
    import pmt_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic [POS_W-1:0]        cur_x_reg, cur_y_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    // x adds dx, y subtracts dy (screen y grows downward)
    assign sum_x = $signed({2'b00, cur_x_reg}) + SUM_W'(move_x);
    assign sum_y = $signed({2'b00, cur_y_reg}) - SUM_W'(move_y);

    always_comb
    begin
        if (sum_x < 0)
            pos_x_next = '0;
        else if (sum_x > $signed({2'b00, x_limit}))
            pos_x_next = x_limit;
        else
            pos_x_next = sum_x[POS_W-1:0];

        if (sum_y < 0)
            pos_y_next = '0;
        else if (sum_y > $signed({2'b00, y_limit}))
            pos_y_next = y_limit;
        else
            pos_y_next = sum_y[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else if (step)
        begin
            cur_x_reg <= pos_x_next;
            cur_y_reg <= pos_y_next;
        end
    end

endmodule

`default_nettype wire
